[design/knn4h_pkg.sv]
// Shared types and constants for the 4-ary heap k-smallest selector.
// Used by knn4h_sift_eng and knn_four_ary_heap_select; no dependencies.
package knn4h_pkg;

  localparam int HEAP_DEPTH = 64;
  localparam int SLOT_W     = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int CHILD_W    = SLOT_W + 2;
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int REQ_W      = 2;

  localparam logic [CNT_W-1:0] K_RESET = CNT_W'(16);

  // request codes on in_req_type
  localparam logic [REQ_W-1:0] REQ_OFFER = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // engine operations
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  val;
    logic [CNT_W-1:0]  k;
  } eng_cmd_t;

  typedef struct packed {
    logic             done;
    logic [KEY_W-1:0] rd_key;
    logic [VAL_W-1:0] rd_val;
    logic [KEY_W-1:0] root_key;
  } eng_stat_t;

endpackage

[design/knn4h_sift_eng.sv]
// Heap storage and sift-down engine: one synchronous RAM of (key, index)
// entries, read one child per cycle. Depends on knn4h_pkg.
module knn4h_sift_eng import knn4h_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  eng_cmd_t  cmd,
  output eng_stat_t stat
);

  localparam logic [2:0] E_IDLE   = 3'd0;
  localparam logic [2:0] E_LEVEL  = 3'd1;
  localparam logic [2:0] E_SCAN   = 3'd2;
  localparam logic [2:0] E_DECIDE = 3'd3;
  localparam logic [2:0] E_FIN    = 3'd4;

  logic [KEY_W+VAL_W-1:0] mem [HEAP_DEPTH];
  logic [KEY_W+VAL_W-1:0] q_r;

  logic                   mem_we, mem_re;
  logic [SLOT_W-1:0]      mem_waddr, mem_raddr;
  logic [KEY_W+VAL_W-1:0] mem_wdata;

  logic [2:0]        st_r, st_nxt;
  logic [SLOT_W-1:0] pos_r, pos_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [CHILD_W-1:0] ca_r, ca_nxt;
  logic [1:0]        rcv_r, rcv_nxt;
  logic [KEY_W-1:0]  best_key_r, best_key_nxt;
  logic [VAL_W-1:0]  best_val_r, best_val_nxt;
  logic [SLOT_W-1:0] best_slot_r, best_slot_nxt;
  logic [KEY_W-1:0]  root_r;

  logic [KEY_W-1:0]   q_key;
  logic [VAL_W-1:0]   q_val;
  logic [CHILD_W-1:0] child_base, next_ca, k_ext;
  logic               more, take;

  assign q_key      = q_r[KEY_W+VAL_W-1:VAL_W];
  assign q_val      = q_r[VAL_W-1:0];
  assign k_ext      = {1'b0, k_r};
  assign child_base = {pos_r, 2'b00} + CHILD_W'(1);
  assign next_ca    = ca_r + CHILD_W'(1);
  assign more       = (rcv_r != 2'd3) && (next_ca < k_ext);
  // first child always taken; later ones only when strictly larger
  assign take       = (rcv_r == 2'd0) || (q_key > best_key_r);

  // RAM: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) q_r <= mem[mem_raddr];
  end

  always_comb begin
    st_nxt        = st_r;
    pos_nxt       = pos_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    k_nxt         = k_r;
    ca_nxt        = ca_r;
    rcv_nxt       = rcv_r;
    best_key_nxt  = best_key_r;
    best_val_nxt  = best_val_r;
    best_slot_nxt = best_slot_r;
    mem_we        = 1'b0;
    mem_waddr     = pos_r;
    mem_wdata     = {key_r, val_r};
    mem_re        = 1'b0;
    mem_raddr     = ca_r[SLOT_W-1:0];
    unique case (st_r)
      E_IDLE: begin
        if (start) begin
          key_nxt = cmd.key;
          val_nxt = cmd.val;
          pos_nxt = cmd.slot;
          k_nxt   = cmd.k;
          if (cmd.op == OP_READ) begin
            mem_re    = 1'b1;
            mem_raddr = cmd.slot;
            st_nxt    = E_FIN;
          end else begin
            st_nxt = E_LEVEL;
          end
        end
      end
      E_LEVEL: begin
        if (child_base < k_ext) begin
          mem_re    = 1'b1;
          mem_raddr = child_base[SLOT_W-1:0];
          ca_nxt    = child_base;
          rcv_nxt   = 2'd0;
          st_nxt    = E_SCAN;
        end else begin
          // leaf: settle the held item here
          mem_we = 1'b1;
          st_nxt = E_FIN;
        end
      end
      E_SCAN: begin
        // q_r holds the child at ca_r
        if (take) begin
          best_key_nxt  = q_key;
          best_val_nxt  = q_val;
          best_slot_nxt = ca_r[SLOT_W-1:0];
        end
        if (more) begin
          mem_re    = 1'b1;
          mem_raddr = next_ca[SLOT_W-1:0];
          ca_nxt    = next_ca;
          rcv_nxt   = rcv_r + 2'd1;
        end else begin
          st_nxt = E_DECIDE;
        end
      end
      E_DECIDE: begin
        mem_we = 1'b1;
        if (key_r < best_key_r) begin
          // largest child moves up, held item goes one level down
          mem_wdata = {best_key_r, best_val_r};
          pos_nxt   = best_slot_r;
          st_nxt    = E_LEVEL;
        end else begin
          st_nxt = E_FIN;
        end
      end
      E_FIN: begin
        st_nxt = E_IDLE;
      end
      default: begin
        st_nxt = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= E_IDLE;
      root_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (mem_we && (mem_waddr == '0)) root_r <= mem_wdata[KEY_W+VAL_W-1:VAL_W];
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    key_r       <= key_nxt;
    val_r       <= val_nxt;
    k_r         <= k_nxt;
    ca_r        <= ca_nxt;
    rcv_r       <= rcv_nxt;
    best_key_r  <= best_key_nxt;
    best_val_r  <= best_val_nxt;
    best_slot_r <= best_slot_nxt;
  end

  assign stat.done     = (st_r == E_FIN);
  assign stat.rd_key   = q_key;
  assign stat.rd_val   = q_val;
  assign stat.root_key = root_r;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (st_r == E_IDLE)) else $error("engine started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |=> !stat.done) else $error("done longer than one cycle");
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == E_SCAN) |-> (ca_r < k_ext)) else $error("child read beyond heap size");
  a_root_shadow: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && (mem_waddr == '0)) |=>
      (root_r == $past(mem_wdata[KEY_W+VAL_W-1:VAL_W])))
    else $error("root shadow out of step with slot 0");
`endif

endmodule

[design/knn_four_ary_heap_select.sv]
// k-smallest selector, top level: handshake, k register, fill count,
// result staging. Depends on knn4h_pkg and knn4h_sift_eng.

// Keeps the k smallest (key, index) pairs offered to it in a 4-ary max-heap
// held in one synchronous RAM; slot 0 is the largest kept key. One request
// is worked at a time and every transaction yields exactly one result.
// Clear, unknown requests, rejected offers and reads of unfilled slots skip
// the sift engine; a read of a filled slot does one RAM read; an accepted
// offer walks the heap level by level, reading each child there in turn and
// moving the largest child up while the item is smaller, then writes the
// item where it settles (a leaf write if that slot has no children below
// k), at most three levels of four children for k = 64. The sift-down loop
// fetches one child per cycle from the single RAM read port. A new transaction
// is taken once the previous result sits in the output register, even if it
// is not yet taken downstream. Writing cfg_wdata sets k (values 0 and above 64
// clamp to 1 and 64) and empties the heap; write it only while the block is
// idle. The root key is tracked in a shadow register, so a full-heap offer is
// tested against it without a RAM access. Slot contents survive a clear but
// are no longer reported.
module knn_four_ary_heap_select import knn4h_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [KEY_W-1:0]  in_cand_key,
  input  logic [VAL_W-1:0]  in_cand_value,
  input  logic [SLOT_W-1:0] in_read_slot,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_accepted,
  output logic [KEY_W-1:0]  out_slot_key,
  output logic [VAL_W-1:0]  out_slot_value,
  output logic [KEY_W-1:0]  out_root_key,
  output logic [CNT_W-1:0]  out_kept_count,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_WAIT = 2'd1;
  localparam logic [1:0] T_HOLD = 2'd2;

  logic [1:0]       st_r, st_nxt;
  logic [CNT_W-1:0] k_r;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             rd_pend_r, rd_pend_nxt;

  // result waiting for the output register
  logic             res_acc_r, res_acc_nxt;
  logic [KEY_W-1:0] res_skey_r, res_skey_nxt;
  logic [VAL_W-1:0] res_sval_r, res_sval_nxt;
  logic [KEY_W-1:0] res_root_r, res_root_nxt;

  logic             out_valid_r;
  logic             out_acc_r;
  logic [KEY_W-1:0] out_skey_r, out_root_r;
  logic [VAL_W-1:0] out_sval_r;
  logic [CNT_W-1:0] out_cnt_r;

  logic      start;
  eng_cmd_t  cmd;
  eng_stat_t stat;

  logic             in_fire, full, slot_ok, out_load;
  logic [CNT_W-1:0] slot_ext, k_clamped, fill_slot;

  knn4h_sift_eng u_eng (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .cmd   (cmd),
    .stat  (stat)
  );

  assign in_ready  = (st_r == T_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign full      = (fill_r == k_r);
  assign slot_ext  = {1'b0, in_read_slot};
  assign slot_ok   = (slot_ext < k_r) && (slot_ext >= (k_r - fill_r));
  // filling proceeds from the last slot toward the root
  assign fill_slot = k_r - CNT_W'(1) - fill_r;
  assign out_load  = (st_r == T_HOLD) && (!out_valid_r || out_ready);

  assign k_clamped = (cfg_wdata == '0) ? CNT_W'(1) :
                     (cfg_wdata > CNT_W'(HEAP_DEPTH)) ? CNT_W'(HEAP_DEPTH) : cfg_wdata;

  always_comb begin
    st_nxt       = st_r;
    fill_nxt     = fill_r;
    rd_pend_nxt  = rd_pend_r;
    res_acc_nxt  = res_acc_r;
    res_skey_nxt = res_skey_r;
    res_sval_nxt = res_sval_r;
    res_root_nxt = res_root_r;
    start        = 1'b0;
    cmd.op       = OP_INSERT;
    cmd.slot     = fill_slot[SLOT_W-1:0];
    cmd.key      = in_cand_key;
    cmd.val      = in_cand_value;
    cmd.k        = k_r;
    unique case (st_r)
      T_IDLE: begin
        if (in_fire) begin
          res_acc_nxt  = 1'b0;
          res_skey_nxt = '0;
          res_sval_nxt = '0;
          rd_pend_nxt  = 1'b0;
          st_nxt       = T_HOLD;
          unique case (in_req_type)
            REQ_OFFER: begin
              if (!full) begin
                start       = 1'b1;
                fill_nxt    = fill_r + CNT_W'(1);
                res_acc_nxt = 1'b1;
                st_nxt      = T_WAIT;
              end else if (in_cand_key < stat.root_key) begin
                start       = 1'b1;
                cmd.slot    = '0;
                res_acc_nxt = 1'b1;
                st_nxt      = T_WAIT;
              end
            end
            REQ_READ: begin
              if (slot_ok) begin
                start       = 1'b1;
                cmd.op      = OP_READ;
                cmd.slot    = in_read_slot;
                rd_pend_nxt = 1'b1;
                st_nxt      = T_WAIT;
              end
            end
            REQ_CLEAR: begin
              fill_nxt = '0;
            end
            default: begin
            end
          endcase
          res_root_nxt = (fill_nxt == k_r) ? stat.root_key : '0;
        end
      end
      T_WAIT: begin
        if (stat.done) begin
          if (rd_pend_r) begin
            res_skey_nxt = stat.rd_key;
            res_sval_nxt = stat.rd_val;
          end
          res_root_nxt = full ? stat.root_key : '0;
          st_nxt       = T_HOLD;
        end
      end
      T_HOLD: begin
        if (out_load) st_nxt = T_IDLE;
      end
      default: begin
        st_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      k_r         <= K_RESET;
      fill_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      rd_pend_r <= rd_pend_nxt;
      if (cfg_we) begin
        k_r    <= k_clamped;
        fill_r <= '0;
      end else begin
        fill_r <= fill_nxt;
      end
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res_acc_r  <= res_acc_nxt;
    res_skey_r <= res_skey_nxt;
    res_sval_r <= res_sval_nxt;
    res_root_r <= res_root_nxt;
    if (out_load) begin
      out_acc_r  <= res_acc_r;
      out_skey_r <= res_skey_r;
      out_sval_r <= res_sval_r;
      out_root_r <= res_root_r;
      out_cnt_r  <= fill_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_acc_r;
  assign out_slot_key   = out_skey_r;
  assign out_slot_value = out_sval_r;
  assign out_root_key   = out_root_r;
  assign out_kept_count = out_cnt_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= k_r) && (k_r != '0) && (k_r <= CNT_W'(HEAP_DEPTH)))
    else $error("fill count or k out of range");
  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> (st_r == T_WAIT)) else $error("engine done with no transaction pending");
  a_start_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> in_fire) else $error("engine started without a transaction");
`endif

endmodule

[verif/knn_four_ary_heap_select_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for knn_four_ary_heap_select (4-ary max-heap k-smallest selector).
// Depends on knn4h_pkg and the design sources; a local heap model predicts every result.
module knn_four_ary_heap_select_tb;
  import knn4h_pkg::*;

  // req_type 3 has no package name; the block must treat it as a no-op
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  // quiet cycles (no transaction on either channel) before the run is declared hung;
  // the receiver hold-off below is the longest legal quiet stretch
  localparam int STALL_LIMIT    = 4000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int END_DRAIN      = 30;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic             acc;
    logic [KEY_W-1:0] skey;
    logic [VAL_W-1:0] sval;
    logic [KEY_W-1:0] root;
    logic [CNT_W-1:0] cnt;
  } heap_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [REQ_W-1:0]  in_req_type;
  logic [KEY_W-1:0]  in_cand_key;
  logic [VAL_W-1:0]  in_cand_value;
  logic [SLOT_W-1:0] in_read_slot;
  logic              out_valid;
  logic              out_ready;
  logic              out_accepted;
  logic [KEY_W-1:0]  out_slot_key;
  logic [VAL_W-1:0]  out_slot_value;
  logic [KEY_W-1:0]  out_root_key;
  logic [CNT_W-1:0]  out_kept_count;
  logic              cfg_we;
  logic [CNT_W-1:0]  cfg_wdata;

  // shadow copy of the heap, fill count and k register
  logic [KEY_W-1:0]  shadow_keys [HEAP_DEPTH];
  logic [VAL_W-1:0]  shadow_vals [HEAP_DEPTH];
  int                shadow_fill;
  logic [CNT_W-1:0]  shadow_k;

  heap_result_t      due_results [$];   // predicted results, oldest first
  int                fail_count   = 0;
  int                quiet_cycles = 0;

  // idle_on = 0 gives a stretch where neither side inserts bubbles
  bit                idle_on      = 1'b1;
  bit                rx_hold_req  = 1'b0;
  int                rx_hold_left = 0;

  knn_four_ary_heap_select uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_cand_key    (in_cand_key),
    .in_cand_value  (in_cand_value),
    .in_read_slot   (in_read_slot),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_accepted   (out_accepted),
    .out_slot_key   (out_slot_key),
    .out_slot_value (out_slot_value),
    .out_root_key   (out_root_key),
    .out_kept_count (out_kept_count),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Heap model
  // ---------------------------------------------------------------------------

  // k register clamps to 1 .. HEAP_DEPTH
  function automatic int heap_size(input logic [CNT_W-1:0] kv);
    if (kv == '0) return 1;
    if (int'(kv) > HEAP_DEPTH) return HEAP_DEPTH;
    return int'(kv);
  endfunction

  // largest child wins, first child on ties; swap only if parent strictly smaller
  function automatic void sift_down(input int start, input int ke);
    int s;
    int j;
    int last;
    logic [KEY_W-1:0] tk;
    logic [VAL_W-1:0] tv;
    s = start;
    while (4 * s + 1 < ke) begin
      j    = 4 * s + 1;
      last = (4 * s + 5 > ke) ? ke : 4 * s + 5;
      for (int c = j + 1; c < last; c++) begin
        if (shadow_keys[c] > shadow_keys[j]) j = c;
      end
      if (shadow_keys[s] < shadow_keys[j]) begin
        tk = shadow_keys[s];
        tv = shadow_vals[s];
        shadow_keys[s] = shadow_keys[j];
        shadow_vals[s] = shadow_vals[j];
        shadow_keys[j] = tk;
        shadow_vals[j] = tv;
        s = j;
      end else begin
        break;
      end
    end
  endfunction

  // applies one transaction to the shadow heap and returns the result it must produce
  function automatic heap_result_t heap_step(input logic [REQ_W-1:0]  req,
                                             input logic [KEY_W-1:0]  key,
                                             input logic [VAL_W-1:0]  val,
                                             input logic [SLOT_W-1:0] slot);
    heap_result_t r;
    int ke;
    int p;
    r  = '0;
    ke = heap_size(shadow_k);
    if (shadow_fill > ke) shadow_fill = ke;
    case (req)
      REQ_OFFER: begin
        if (shadow_fill < ke) begin
          // filling: leaves first, from the bottom slot upward
          p = ke - 1 - shadow_fill;
          shadow_keys[p] = key;
          shadow_vals[p] = val;
          if (4 * p + 1 < ke) sift_down(p, ke);
          shadow_fill++;
          r.acc = 1'b1;
        end else if (key < shadow_keys[0]) begin
          // full: strictly smaller key replaces the root
          shadow_keys[0] = key;
          shadow_vals[0] = val;
          sift_down(0, ke);
          r.acc = 1'b1;
        end
      end
      REQ_READ: begin
        // only filled slots report contents
        if (int'(slot) < ke && int'(slot) >= ke - shadow_fill) begin
          r.skey = shadow_keys[slot];
          r.sval = shadow_vals[slot];
        end
      end
      REQ_CLEAR: shadow_fill = 0;
      default: ;
    endcase
    if (shadow_fill == ke) r.root = shadow_keys[0];
    r.cnt = CNT_W'(shadow_fill);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking, sampled at the rising edge
  // ---------------------------------------------------------------------------
  task automatic check_result();
    heap_result_t want;
    heap_result_t got;
    got = '{out_accepted, out_slot_key, out_slot_value, out_root_key, out_kept_count};
    if (due_results.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: result with no transaction pending: acc=%0b skey=%h sval=%h root=%h cnt=%0d",
                 $realtime, got.acc, got.skey, got.sval, got.root, got.cnt);
    end else begin
      want = due_results.pop_front();
      if (got.acc !== want.acc || got.skey !== want.skey || got.sval !== want.sval ||
          got.root !== want.root || got.cnt !== want.cnt) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("%0t: MISMATCH exp acc=%0b skey=%h sval=%h root=%h cnt=%0d",
                   $realtime, want.acc, want.skey, want.sval, want.root, want.cnt);
          $display("%0t:          got acc=%0b skey=%h sval=%h root=%h cnt=%0d",
                   $realtime, got.acc, got.skey, got.sval, got.root, got.cnt);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result();
  end

  // watchdog: counts cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $realtime, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_ready    <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_req) begin
      rx_hold_req   = 1'b0;
      rx_hold_left <= RX_HOLD_CYCLES;
      out_ready    <= 1'b0;
    end else if (!idle_on) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 33);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // One input transaction. in_valid is left high on return so a following call can
  // keep it up; anything else that follows drops it at the next falling edge.
  task automatic send_item(input logic [REQ_W-1:0]  req,
                           input logic [KEY_W-1:0]  key,
                           input logic [VAL_W-1:0]  val,
                           input logic [SLOT_W-1:0] slot);
    if (idle_on) begin
      while ($urandom_range(99) < 33) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_cand_key   <= key;
    in_cand_value <= val;
    in_read_slot  <= slot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    due_results.push_back(heap_step(req, key, val, slot));
  endtask

  // stop offering and wait until every predicted result has been taken
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // k write, only with the block idle; also empties the heap
  task automatic write_k(input logic [CNT_W-1:0] kval);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= kval;
    @(posedge clk);
    shadow_k    = kval;
    shadow_fill = 0;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset k of 16: reads of empty, filled and out-of-range slots, extremes, clear
  task automatic test_reset_defaults();
    send_item(REQ_READ,    '0, '0, 6'd15);   // empty heap
    send_item(REQ_UNKNOWN, '1, '1, '1);
    send_item(REQ_OFFER,   '1, '1, '0);      // lands in slot 15, a leaf
    send_item(REQ_OFFER,   '0, '0, '1);      // slot 14
    send_item(REQ_READ,    '0, '0, 6'd15);
    send_item(REQ_READ,    '1, '1, 6'd14);
    send_item(REQ_READ,    '0, '0, 6'd13);   // below k - fill, not filled
    send_item(REQ_READ,    '0, '0, 6'd63);   // beyond k
    send_item(REQ_CLEAR,   '0, '0, '0);
    send_item(REQ_READ,    '0, '0, 6'd15);   // contents kept but no longer reported
  endtask

  // k = 0 clamps to a one-slot heap: full-heap replace, equal and larger rejects
  task automatic test_single_slot();
    write_k('0);
    send_item(REQ_OFFER,   32'd100, 32'hA5A5_0001, '0);
    send_item(REQ_OFFER,   32'd200, 32'hA5A5_0002, '0);   // larger: rejected
    send_item(REQ_OFFER,   32'd100, 32'hA5A5_0003, '0);   // equal: rejected
    send_item(REQ_OFFER,   32'd50,  32'hA5A5_0004, '0);   // smaller: replaces root
    send_item(REQ_READ,    '0, '0, '0);
    send_item(REQ_UNKNOWN, '0, '0, '0);
    // rewriting k empties the heap even with the same value
    write_k('0);
    send_item(REQ_READ,    '0, '0, '0);
  endtask

  // k = 127 clamps to HEAP_DEPTH; first offer goes to the last slot
  task automatic test_k_max();
    write_k('1);
    send_item(REQ_OFFER, '1, '0, '0);
    send_item(REQ_READ,  '0, '0, 6'd63);
    send_item(REQ_READ,  '0, '0, 6'd0);
  endtask

  // Mostly offers with random content, reads mostly of slots below k, the odd clear and
  // unknown request. Narrow keys force ties in the child compare, and keys at or
  // just under the root hit the equal/smaller boundary once the heap is full.
  task automatic test_random_phase(input logic [CNT_W-1:0] kval, input int n_items,
                                   input int clear_pct);
    int               ke;
    int               pick;
    logic [REQ_W-1:0] req;
    logic [KEY_W-1:0] key;
    logic [SLOT_W-1:0] slot;
    write_k(kval);
    ke = heap_size(kval);
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < clear_pct)          req = REQ_CLEAR;
      else if (pick < clear_pct + 2) req = REQ_UNKNOWN;
      else if (pick < 70)            req = REQ_OFFER;
      else                           req = REQ_READ;
      case ($urandom_range(9))
        0, 1, 2, 3: key = $urandom_range(31);
        4:          key = $urandom_range(1) ? '1 : '0;
        5:          key = shadow_keys[0];
        6:          key = shadow_keys[0] - 1;
        default:    key = $urandom();
      endcase
      if ($urandom_range(4) != 0) slot = SLOT_W'($urandom_range(ke - 1));
      else                        slot = SLOT_W'($urandom_range(63));
      send_item(req, key, $urandom(), slot);
    end
  endtask

  // receiver holds off for a long stretch while the sender keeps offering,
  // so the output register fills and in_ready drops
  task automatic test_output_stall();
    write_k(7'd5);
    rx_hold_req = 1'b1;
    for (int i = 0; i < 24; i++) begin
      send_item((i % 6 == 5) ? REQ_READ : REQ_OFFER, $urandom(), $urandom(),
                SLOT_W'($urandom_range(4)));
    end
  endtask

  // sender pauses until the block has returned everything, then resumes
  task automatic test_sender_pause();
    write_k(7'd9);
    for (int i = 0; i < 12; i++) send_item(REQ_OFFER, $urandom_range(63), $urandom(), '0);
    wait_drained();
    for (int i = 0; i < 12; i++) begin
      send_item((i % 2 == 0) ? REQ_OFFER : REQ_READ, $urandom_range(63), $urandom(),
                SLOT_W'($urandom_range(8)));
    end
  endtask

  initial begin
    // all block inputs known from time zero
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = REQ_OFFER;
    in_cand_key   = '0;
    in_cand_value = '0;
    in_read_slot  = '0;
    out_ready     = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    for (int i = 0; i < HEAP_DEPTH; i++) begin
      shadow_keys[i] = '0;
      shadow_vals[i] = '0;
    end
    shadow_fill = 0;
    shadow_k    = K_RESET;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_single_slot();
    test_k_max();

    // extremes of k first, then a spread; k = 64 gets longer phases with no clears
    test_random_phase(7'd1,   100, 3);
    test_random_phase(7'd64,  200, 0);
    test_random_phase(7'd2,   100, 3);
    test_random_phase(7'd0,   100, 3);
    test_random_phase(7'd127, 200, 0);
    test_random_phase(7'd4,   100, 3);
    test_random_phase(7'd5,   100, 3);
    idle_on = 1'b0;                       // back-to-back stretch, no bubbles either side
    test_random_phase(7'd16,  100, 3);
    idle_on = 1'b1;
    test_random_phase(7'd21,  100, 3);
    for (int p = 0; p < 3; p++) test_random_phase(CNT_W'($urandom_range(20, 1)), 100, 3);
    test_random_phase(CNT_W'($urandom_range(127, 0)), 100, 2);

    test_output_stall();
    test_sender_pause();

    wait_drained();
    repeat (END_DRAIN) @(posedge clk);
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/knn4h_pkg.sv
design/knn4h_sift_eng.sv
design/knn_four_ary_heap_select.sv
verif/knn_four_ary_heap_select_tb.sv
